[rtl/core/prsd_pkg.sv]
// ----------------------------------------------------------------------------
// prsd_pkg
// Shared types, codes and small tables of the palette run-length sprite decoder.
// ----------------------------------------------------------------------------
package prsd_pkg;

	// item kinds on the input channel
	localparam logic OPC_PALETTE = 1'b0;
	localparam logic OPC_DATA    = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_RED_BITS   = 2'd0,
		CFG_GREEN_BITS = 2'd1,
		CFG_BLUE_BITS  = 2'd2,
		CFG_LINE_WIDTH = 2'd3
	} cfg_index_t;

	localparam logic [7:0]  ALPHA_OPAQUE      = 8'hFF;
	localparam logic [7:0]  ALPHA_CLEAR       = 8'h00;
	localparam logic [6:0]  RUN_MASK          = 7'h7F;
	localparam logic [16:0] ROW_COUNT_MAX     = 17'h1FFFF;
	localparam logic [3:0]  CHAN_BITS_DEFAULT = 4'd8;

	typedef logic [23:0] rgb_t;

	// out-of-range bit counts fold to 1..8
	function automatic logic [3:0] clamp_bits(input logic [3:0] n);
		logic [3:0] r;
		r = n;
		if (n == 4'd0)
			r = 4'd1;
		else if (n > 4'd8)
			r = 4'd8;
		return r;
	endfunction

	// largest raw value for a bit count of 1..8
	function automatic logic [7:0] chan_max(input logic [3:0] n);
		logic [7:0] r;
		unique case (n)
			4'd1: r = 8'd1;
			4'd2: r = 8'd3;
			4'd3: r = 8'd7;
			4'd4: r = 8'd15;
			4'd5: r = 8'd31;
			4'd6: r = 8'd63;
			4'd7: r = 8'd127;
			default: r = 8'd255;
		endcase
		return r;
	endfunction

	// floor(2^16 / max) for the reciprocal divide
	function automatic logic [16:0] chan_recip(input logic [3:0] n);
		logic [16:0] r;
		unique case (n)
			4'd1: r = 17'd65536;
			4'd2: r = 17'd21845;
			4'd3: r = 17'd9362;
			4'd4: r = 17'd4369;
			4'd5: r = 17'd2114;
			4'd6: r = 17'd1040;
			4'd7: r = 17'd516;
			default: r = 17'd257;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/prsd_scaler.sv]
// ----------------------------------------------------------------------------
// prsd_scaler
// Two-stage channel scaler: floor(255 * v / (2^n - 1)) by reciprocal multiply.
// ----------------------------------------------------------------------------
module prsd_scaler (
	input  logic       clk,
	input  logic       load,
	input  logic [7:0] raw,
	input  logic [3:0] bit_count,
	output logic [7:0] scaled
);
	import prsd_pkg::*;

	logic [7:0]  v_s1;
	logic [7:0]  m_s1;
	logic [16:0] recip_s1;
	logic [15:0] x_s1;
	logic [32:0] prod_s1;

	logic [15:0] x_s2;
	logic [7:0]  m_s2;
	logic [7:0]  q0_s2;
	logic [15:0] qm_s2;
	logic [15:0] rem_s2;

	// stage 1 takes the raw value masked to the bits in use
	always_ff @(posedge clk) begin
		if (load) begin
			v_s1     <= raw & chan_max(bit_count);
			m_s1     <= chan_max(bit_count);
			recip_s1 <= chan_recip(bit_count);
		end
	end

	// 255 * v, then the estimate that is at most one below the quotient
	assign x_s1    = {v_s1, 8'h00} - 16'(v_s1);
	assign prod_s1 = 33'(x_s1) * 33'(recip_s1);

	always_ff @(posedge clk) begin
		x_s2  <= x_s1;
		m_s2  <= m_s1;
		q0_s2 <= prod_s1[23:16];
	end

	// one correction step
	assign qm_s2  = 16'(q0_s2) * 16'(m_s2);
	assign rem_s2 = x_s2 - qm_s2;
	assign scaled = (rem_s2 >= 16'(m_s2)) ? q0_s2 + 8'd1 : q0_s2;

endmodule

[rtl/core/prsd_palette_ram.sv]
// ----------------------------------------------------------------------------
// prsd_palette_ram
// Colour table: one write port, one registered read port with write forwarding.
// ----------------------------------------------------------------------------
module prsd_palette_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  prsd_pkg::rgb_t wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output prsd_pkg::rgb_t rdata
);
	import prsd_pkg::*;

	rgb_t mem [DEPTH];
	rgb_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// a read of the entry being written returns the new colour
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr))
				rdata_q <= wdata;
			else
				rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/palette_rle_sprite_decoder.sv]
// ----------------------------------------------------------------------------
// palette_rle_sprite_decoder
// Run-length sprite byte decoder with a scaled 256-colour palette.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): opcode 0 loads a palette entry from
//   palette_slot and the raw channels, opcode 1 carries one code_byte of the
//   run-length stream. output channel (out_valid / out_stall) gives at most
//   one span per data byte. the config channel (cfg_valid / cfg_ready, always
//   ready) writes bit counts and the row width; the user must write them only
//   while the block is idle; the block itself does not enforce this.
// throughput and palette loads
//   a data byte's span sits in the output register in the cycle after its
//   transaction; data bytes go at one per cycle when the input is not stalled.
//   a palette load passes a two-stage scaler into the colour table; the input
//   stalls while it is in the first stage, so a following index byte reads
//   the new entry (the last stage is forwarded by the table's read port).
// stalls and reset
//   while a span waits in the output register under out_stall, the input
//   stalls as well. reset clears the run and row counters and restores the
//   default configuration; the colour table is not cleared.
// ----------------------------------------------------------------------------
module palette_rle_sprite_decoder #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  palette_slot,
	input  logic [7:0]  red_raw,
	input  logic [7:0]  green_raw,
	input  logic [7:0]  blue_raw,
	input  logic [7:0]  code_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] span_length,
	output logic [7:0]  alpha,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        row_end,
	output logic        row_overflow,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  prsd_pkg::cfg_index_t cfg_index,
	input  logic [15:0] cfg_data
);
	import prsd_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	// configuration registers
	logic [3:0]  red_bits_q;
	logic [3:0]  green_bits_q;
	logic [3:0]  blue_bits_q;
	logic [15:0] line_width_q;

	// decoder state
	logic [6:0]  opaque_left_q;
	logic [16:0] row_count_q;

	// palette load tracking
	logic          pal_s1_q;
	logic          pal_s2_q;
	logic          slot_ok_s1;
	logic          slot_ok_s2;
	logic [AW-1:0] slot_s1;
	logic [AW-1:0] slot_s2;

	// output register
	logic        out_valid_q;
	logic [15:0] out_len_q;
	logic [7:0]  out_alpha_q;
	logic        out_end_q;
	logic        out_ovf_q;
	logic        out_opq_q;
	logic        out_hit_q;

	logic acc;
	logic acc_pal;
	logic acc_data;

	logic [7:0] red_scaled;
	logic [7:0] green_scaled;
	logic [7:0] blue_scaled;
	rgb_t       rd_colour;
	logic       idx_ok;
	logic       slot_ok;
	logic       mem_re;

	// decode of one data byte
	logic        run_active;
	logic [17:0] row_sum;
	logic [16:0] row_sat;
	logic        row_long;
	logic [15:0] row_pad;
	logic        emit;
	logic [15:0] emit_len;
	logic [7:0]  emit_alpha;
	logic        emit_opq;
	logic        emit_end;
	logic        emit_ovf;
	logic [6:0]  opaque_next;
	logic [16:0] row_next;

	// --- handshakes ---
	// hold the input behind a palette load still in its first scaler stage,
	// and behind a span that the receiver has not taken
	assign in_stall  = pal_s1_q | (out_valid_q & out_stall);
	assign acc       = in_valid & ~in_stall;
	assign acc_pal   = acc & (opcode == OPC_PALETTE);
	assign acc_data  = acc & (opcode == OPC_DATA);
	assign cfg_ready = 1'b1;

	// --- configuration ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_bits_q   <= CHAN_BITS_DEFAULT;
			green_bits_q <= CHAN_BITS_DEFAULT;
			blue_bits_q  <= CHAN_BITS_DEFAULT;
			line_width_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RED_BITS:   red_bits_q   <= cfg_data[3:0];
				CFG_GREEN_BITS: green_bits_q <= cfg_data[3:0];
				CFG_BLUE_BITS:  blue_bits_q  <= cfg_data[3:0];
				CFG_LINE_WIDTH: line_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// --- palette load path ---
	prsd_scaler u_scale_red (
		.clk       (clk),
		.load      (acc_pal),
		.raw       (red_raw),
		.bit_count (clamp_bits(red_bits_q)),
		.scaled    (red_scaled)
	);

	prsd_scaler u_scale_green (
		.clk       (clk),
		.load      (acc_pal),
		.raw       (green_raw),
		.bit_count (clamp_bits(green_bits_q)),
		.scaled    (green_scaled)
	);

	prsd_scaler u_scale_blue (
		.clk       (clk),
		.load      (acc_pal),
		.raw       (blue_raw),
		.bit_count (clamp_bits(blue_bits_q)),
		.scaled    (blue_scaled)
	);

	// slots beyond the table are dropped
	assign slot_ok = 9'(palette_slot) < 9'(PALETTE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_s1_q <= 1'b0;
			pal_s2_q <= 1'b0;
		end else begin
			pal_s1_q <= acc_pal;
			pal_s2_q <= pal_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_pal) begin
			slot_s1    <= palette_slot[AW-1:0];
			slot_ok_s1 <= slot_ok;
		end
		slot_s2    <= slot_s1;
		slot_ok_s2 <= slot_ok_s1;
	end

	// --- colour table ---
	assign idx_ok = 9'(code_byte) < 9'(PALETTE_ENTRIES);
	assign mem_re = acc_data & run_active & idx_ok;

	prsd_palette_ram #(
		.DEPTH (PALETTE_ENTRIES),
		.AW    (AW)
	) u_palette (
		.clk   (clk),
		.we    (pal_s2_q & slot_ok_s2),
		.waddr (slot_s2),
		.wdata ({red_scaled, green_scaled, blue_scaled}),
		.re    (mem_re),
		.raddr (code_byte[AW-1:0]),
		.rdata (rd_colour)
	);

	// --- data byte decode ---
	assign run_active = opaque_left_q != 7'd0;
	// the low seven bits are the count for both skip and run codes
	assign row_sum    = {1'b0, row_count_q} + 18'(code_byte[6:0] & RUN_MASK);
	assign row_sat    = row_sum[17] ? ROW_COUNT_MAX : row_sum[16:0];
	assign row_long   = row_count_q > {1'b0, line_width_q};
	assign row_pad    = line_width_q - row_count_q[15:0];

	always_comb begin
		emit        = 1'b0;
		emit_len    = '0;
		emit_alpha  = ALPHA_CLEAR;
		emit_opq    = 1'b0;
		emit_end    = 1'b0;
		emit_ovf    = 1'b0;
		opaque_next = opaque_left_q;
		row_next    = row_count_q;
		priority if (run_active) begin
			// index byte inside an opaque run
			emit        = 1'b1;
			emit_len    = 16'd1;
			emit_alpha  = ALPHA_OPAQUE;
			emit_opq    = 1'b1;
			opaque_next = opaque_left_q - 7'd1;
		end else if (code_byte == 8'h00) begin
			// end of row: pad up to the width, or flag a long row
			emit     = 1'b1;
			emit_len = row_long ? 16'd0 : row_pad;
			emit_end = 1'b1;
			emit_ovf = row_long;
			row_next = '0;
		end else if (code_byte[7]) begin
			// transparent skip, empty skip gives nothing
			emit     = code_byte[6:0] != 7'd0;
			emit_len = 16'(code_byte[6:0]);
			row_next = row_sat;
		end else begin
			// opaque run opens, counted in full now
			opaque_next = code_byte[6:0];
			row_next    = row_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opaque_left_q <= '0;
			row_count_q   <= '0;
		end else if (acc_data) begin
			opaque_left_q <= opaque_next;
			row_count_q   <= row_next;
		end
	end

	// --- output register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (acc_data)
			out_valid_q <= emit;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc_data) begin
			out_len_q   <= emit_len;
			out_alpha_q <= emit_alpha;
			out_end_q   <= emit_end;
			out_ovf_q   <= emit_ovf;
			out_opq_q   <= emit_opq;
			out_hit_q   <= idx_ok;
		end
	end

	assign out_valid    = out_valid_q;
	assign span_length  = out_len_q;
	assign alpha        = out_alpha_q;
	assign row_end      = out_end_q;
	assign row_overflow = out_ovf_q;
	// colour comes straight from the table's read register
	assign red   = (out_opq_q && out_hit_q) ? rd_colour[23:16] : 8'h00;
	assign green = (out_opq_q && out_hit_q) ? rd_colour[15:8]  : 8'h00;
	assign blue  = (out_opq_q && out_hit_q) ? rd_colour[7:0]   : 8'h00;

	// --- assertions ---
	// an opaque pixel is always a single pixel and never closes a row
	a_opaque_single : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (alpha == ALPHA_OPAQUE)) |-> ((span_length == 16'd1) && !row_end))
		else $error("opaque span is not a single pixel");

	// a row end is transparent, and an overflowed row pads nothing
	a_row_end_shape : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && row_end) |-> ((alpha == ALPHA_CLEAR) &&
			(!row_overflow || (span_length == 16'd0))))
		else $error("malformed row end span");

	// a zero code outside a run closes the row and always shows a span
	a_row_close : assert property (@(posedge clk) disable iff (!arst_n)
		(acc_data && !run_active && (code_byte == 8'h00)) |=>
			((row_count_q == 17'd0) && out_valid && row_end))
		else $error("row end did not clear the row count");

	// no item is taken while a palette load is before the forwarded stage
	a_pal_interlock : assert property (@(posedge clk) disable iff (!arst_n)
		pal_s1_q |-> !acc)
		else $error("item accepted over a pending palette load");

endmodule

[sim/palette_rle_sprite_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_rle_sprite_decoder_test
// Self-checking bench for the run-length sprite decoder: a queue-fed driver
// and a clocked monitor with a cycle-free span predictor and scoreboard.
// ----------------------------------------------------------------------------
module palette_rle_sprite_decoder_test;
	import prsd_pkg::*;

	// one input transaction as it appears on the ports
	typedef struct packed {
		logic       opc;
		logic [7:0] slot;
		logic [7:0] r_raw;
		logic [7:0] g_raw;
		logic [7:0] b_raw;
		logic [7:0] code;
	} sprite_item_t;

	// one output span as it appears on the ports
	typedef struct packed {
		logic [15:0] len;
		logic [7:0]  a;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic        eor;
		logic        ovf;
	} span_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = OPC_PALETTE;
	logic [7:0]  palette_slot = '0;
	logic [7:0]  red_raw = '0;
	logic [7:0]  green_raw = '0;
	logic [7:0]  blue_raw = '0;
	logic [7:0]  code_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] span_length;
	logic [7:0]  alpha;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        row_end;
	logic        row_overflow;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_index_t  cfg_index = CFG_RED_BITS;
	logic [15:0] cfg_data = '0;

	// stimulus side: items waiting for the driver and the generator's view
	// of the stream (open run length, which palette slots hold a colour)
	sprite_item_t sprite_stream[$];
	logic [7:0]   loaded_slots[$];
	bit           slot_loaded[256];
	int           gen_run_left = 0;
	bit           quiet = 1'b0;
	bit           in_taken = 1'b0;

	// predictor state, mirrors the decoder after each accepted transaction
	rgb_t         palette_shadow[256];
	logic [6:0]   run_left = '0;
	logic [16:0]  row_pixels = '0;
	logic [3:0]   bits_red = CHAN_BITS_DEFAULT;
	logic [3:0]   bits_green = CHAN_BITS_DEFAULT;
	logic [3:0]   bits_blue = CHAN_BITS_DEFAULT;
	logic [15:0]  line_width = '0;
	span_t        pending_spans[$];
	int           mismatches = 0;

	palette_rle_sprite_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.palette_slot (palette_slot),
		.red_raw      (red_raw),
		.green_raw    (green_raw),
		.blue_raw     (blue_raw),
		.code_byte    (code_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.span_length  (span_length),
		.alpha        (alpha),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.row_end      (row_end),
		.row_overflow (row_overflow),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// roughly one cycle in four idles, except during a quiet stretch
	function automatic bit take_break();
		return !quiet && ($urandom_range(0, 99) < 24);
	endfunction

	// raw channel to 8 bits: 255 * v / (2^bits - 1), bit count folded to 1..8
	function automatic logic [7:0] scale_chan(input logic [7:0] raw, input logic [3:0] bits);
		int n;
		int top;
		n = (bits == 0) ? 1 : ((bits > 8) ? 8 : int'(bits));
		top = (1 << n) - 1;
		return 8'((255 * (int'(raw) & top)) / top);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string field, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
	endtask

	// advance the predictor by one accepted transaction, queue its span if any
	task automatic predict_span(input sprite_item_t it);
		span_t      s;
		logic [17:0] sum;
		s = '0;
		if (it.opc == OPC_PALETTE) begin
			palette_shadow[it.slot] = {scale_chan(it.r_raw, bits_red),
				scale_chan(it.g_raw, bits_green), scale_chan(it.b_raw, bits_blue)};
			return;
		end
		if (run_left != 0) begin
			// inside an opaque run every byte is a palette index
			run_left = run_left - 7'd1;
			s.len = 16'd1;
			s.a = ALPHA_OPAQUE;
			{s.r, s.g, s.b} = palette_shadow[it.code];
		end else if (it.code == 8'h00) begin
			// row close: pad to width, or flag an overlong row
			s.eor = 1'b1;
			s.a = ALPHA_CLEAR;
			if (row_pixels > {1'b0, line_width})
				s.ovf = 1'b1;
			else
				s.len = 16'({1'b0, line_width} - row_pixels);
			row_pixels = '0;
		end else begin
			sum = row_pixels + it.code[6:0];
			row_pixels = (sum > ROW_COUNT_MAX) ? ROW_COUNT_MAX : sum[16:0];
			if (!it.code[7]) begin
				// run opens, whole length counted now, nothing emitted
				run_left = it.code[6:0];
				return;
			end
			// empty transparent span emits nothing
			if (it.code[6:0] == 7'd0)
				return;
			s.len = 16'(it.code[6:0]);
			s.a = ALPHA_CLEAR;
		end
		pending_spans.push_back(s);
	endtask

	// driver: next item goes out at the falling edge once the last one is taken
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (sprite_stream.size() != 0 && !take_break()) begin
				sprite_item_t it;
				it = sprite_stream.pop_front();
				opcode       <= it.opc;
				palette_slot <= it.slot;
				red_raw      <= it.r_raw;
				green_raw    <= it.g_raw;
				blue_raw     <= it.b_raw;
				code_byte    <= it.code;
				in_valid     <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= take_break();
	end

	// monitor: check spans first, then predict from the input transaction
	always @(posedge clk) begin : monitor
		span_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (pending_spans.size() == 0) begin
					report_mismatch("span with no prediction waiting");
				end else begin
					want = pending_spans.pop_front();
					check_field("span_length", span_length, want.len);
					check_field("alpha", alpha, want.a);
					check_field("red", red, want.r);
					check_field("green", green, want.g);
					check_field("blue", blue, want.b);
					check_field("row_end", row_end, want.eor);
					check_field("row_overflow", row_overflow, want.ovf);
				end
			end
			if (in_valid && !in_stall)
				predict_span({opcode, palette_slot, red_raw, green_raw, blue_raw, code_byte});
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RED_BITS: begin
						bits_red = cfg_data[3:0];
					end
					CFG_GREEN_BITS: begin
						bits_green = cfg_data[3:0];
					end
					CFG_BLUE_BITS: begin
						bits_blue = cfg_data[3:0];
					end
					CFG_LINE_WIDTH: begin
						line_width = cfg_data;
					end
				endcase
			end
		end
	end

	// palette load; the data byte field carries noise
	task automatic load_entry(input logic [7:0] slot, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		sprite_item_t it;
		it.opc = OPC_PALETTE;
		it.slot = slot;
		it.r_raw = r;
		it.g_raw = g;
		it.b_raw = b;
		it.code = 8'($urandom());
		sprite_stream.push_back(it);
		if (!slot_loaded[slot]) begin
			slot_loaded[slot] = 1'b1;
			loaded_slots.push_back(slot);
		end
	endtask

	// coded byte; palette fields carry noise
	task automatic send_code(input logic [7:0] code);
		sprite_item_t it;
		it.opc = OPC_DATA;
		it.slot = 8'($urandom());
		it.r_raw = 8'($urandom());
		it.g_raw = 8'($urandom());
		it.b_raw = 8'($urandom());
		it.code = code;
		sprite_stream.push_back(it);
		if (gen_run_left != 0)
			gen_run_left--;
		else if (code != 8'h00 && !code[7])
			gen_run_left = code[6:0];
	endtask

	// index bytes only ever name a slot that already holds a colour
	task automatic send_index();
		send_code(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			load_entry(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
		else if (gen_run_left != 0)
			send_index();
		else if (pick < 20)
			send_code(8'h00);
		else if (pick < 40)
			send_code({1'b1, 7'($urandom_range(0, 15))});
		else if (pick < 55)
			send_code({1'b1, 7'($urandom())});
		else if (pick < 97)
			send_code({1'b0, 7'($urandom_range(1, 8))});
		else
			send_code({1'b0, 7'($urandom_range(100, 127))});
	endtask

	// complete any open run and close the row so a phase ends cleanly
	task automatic close_rows();
		while (gen_run_left != 0)
			send_index();
		send_code(8'h00);
	endtask

	// idle: nothing queued or on the wire, every span seen, scaler flushed
	task automatic wait_idle();
		while (sprite_stream.size() != 0 || in_valid || pending_spans.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: 8-bit channels, zero row width
		load_entry(8'd0, 8'hFF, 8'h00, 8'h80);
		load_entry(8'd255, 8'h00, 8'hFF, 8'h01);
		send_code(8'h00);           // empty row, zero padding
		send_code(8'h80);           // empty transparent span, silent
		send_code(8'h81);
		send_code(8'h00);           // overlong row against width 0
		send_code(8'hFF);           // longest transparent span
		send_code(8'h02);           // opaque run of two
		load_entry(8'd1, 8'h12, 8'h34, 8'h56);  // load inside a pending run
		send_code(8'h01);           // reads the entry just loaded
		send_code(8'hFF);           // top bit set but still an index
		send_code(8'h00);
		wait_idle();

		// bit counts below and above range, widest row
		write_reg(CFG_RED_BITS, 16'd0);
		write_reg(CFG_GREEN_BITS, 16'd15);
		write_reg(CFG_BLUE_BITS, 16'd1);
		write_reg(CFG_LINE_WIDTH, 16'hFFFF);
		load_entry(8'd2, 8'hFE, 8'h7F, 8'hFF);
		load_entry(8'd3, 8'hFF, 8'h80, 8'hFE);
		send_code(8'h02);
		send_code(8'h02);
		send_code(8'h03);
		send_code(8'h00);
		wait_idle();

		// long transparent row padded against the widest row
		repeat (40) send_code(8'hFF);
		send_code(8'h00);
		wait_idle();

		// random phases under different settings, one of them without idling
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_RED_BITS, 16'($urandom_range(0, 15)));
			write_reg(CFG_GREEN_BITS, 16'($urandom_range(0, 15)));
			write_reg(CFG_BLUE_BITS, 16'($urandom_range(0, 15)));
			write_reg(CFG_LINE_WIDTH, (ph == 1) ? 16'd0 : 16'($urandom_range(1, 200)));
			quiet = (ph == 2);
			repeat (85) random_item();
			close_rows();
			wait_idle();
			quiet = 1'b0;
		end

		if (mismatches == 0)
			$display("palette_rle_sprite_decoder verification clean");
		else
			$display("palette_rle_sprite_decoder verification failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("palette_rle_sprite_decoder verification failed");
		$finish;
	end

endmodule
